### sv/assert_macros.svh
// Assertion macros shared by the slab allocator RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/sba_pkg.sv
// Package for the slab block allocator: types, constants, state codes.
// No dependencies.
package sba_pkg;
   localparam int unsigned PAGES          = 16;
   localparam int unsigned SLOTS_PER_PAGE = 255;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned OFS_W   = 24;
   localparam int unsigned TOTAL_W = 12;
   localparam int unsigned BSZ_W   = 16;
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_OUT
   } state_type;
endpackage

### sv/sba_stack_mem.sv
// Slot stack memory of the slab allocator: one write port, one registered read port.
// Depends on sba_pkg.
module sba_stack_mem
   import sba_pkg::*;
#(
   parameter int unsigned DEPTH = 4080,
   parameter int unsigned AW    = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [SLOT_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [SLOT_W-1:0] rd_data
);
   logic [SLOT_W-1:0] mem [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/slab_block_allocator.sv
// Top level of the slab block allocator: page list control and result register.
// Depends on sba_pkg, sba_stack_mem and assert_macros.svh.
//
// channel  | dir | beat contents
// req      | in  | tuser = func; tdata = free_page [3:0], free_slot [11:4]
// rsp      | out | tuser = status; tdata = alloc_page, alloc_slot, byte_offset,
//          |     |   free_blocks, pages_with_free (low bit up), zero filled
// csr      | in  | slot size in bytes, no handshake
//
// Each request goes through accept, stack memory read/write plus list update,
// then the result is held in the output register until taken. A new request
// is accepted once the previous result beat has been taken; the response
// handshake sets the pace.
// Reset clears the per-page depth, low-water marks and links in flip-flops at
// once; the stack memory itself is never cleared (low-water mark covers it).
`include "assert_macros.svh"
module slab_block_allocator
   import sba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // free_page, free_slot, zeros
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // alloc_page, alloc_slot, byte_offset, free_blocks,
                                    // pages_with_free, zeros
   output logic        rsp_tuser    // status
);
   localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int unsigned LW    = $clog2(PAGES + 1);
   localparam int unsigned DEPTH = PAGES * SLOTS_PER_PAGE;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam logic [LW-1:0] NIL = LW'(PAGES);
   localparam logic [SLOT_W-1:0] SPP = SLOT_W'(SLOTS_PER_PAGE);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0] depth_ff [PAGES];
   logic [SLOT_W-1:0] lwm_ff   [PAGES];
   logic [LW-1:0]     next_ff  [PAGES];
   logic [LW-1:0]     prev_ff  [PAGES];
   logic [LW-1:0]     head_ff;
   logic [LW-1:0]     opened_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [LW-1:0]     listed_ff;
   logic [BSZ_W-1:0]  bsz_ff;

   // Latched request and decisions for the execute cycle.
   logic              func_ff;
   logic [PW-1:0]     pg_ff;
   logic [SLOT_W-1:0] sl_ff;
   logic [SLOT_W-1:0] pos_ff;
   logic              act_ff;   // alloc pops, or free pushes
   logic              fail_ff;
   logic              lwm_hit_ff;

   // Result register.
   logic                status_ff;
   logic [PW-1:0]       rpage_ff;
   logic [SLOT_W-1:0]   rslot_ff;
   logic [OFS_W-1:0]    rofs_ff;

   logic              req_fire;
   logic              in_func;
   logic [PW-1:0]     in_pg;
   logic [SLOT_W-1:0] in_sl;
   logic [PW-1:0]     hp;
   logic              open_new;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] rd_data, slot_val;

   assign req_fire = req_tvalid && req_tready;
   assign in_func  = req_tuser;
   assign in_pg    = req_tdata[PW-1:0];
   assign in_sl    = req_tdata[4 +: SLOT_W];
   assign hp       = head_ff[PW-1:0];
   assign open_new = (head_ff == NIL) && (opened_ff < LW'(PAGES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_OUT;
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stack address: page base plus position; read for pops, write for pushes.
   logic [PW-1:0]     dec_pg;
   logic [SLOT_W-1:0] dec_pos;
   assign dec_pg  = (in_func == FUNC_FREE) ? in_pg : (open_new ? opened_ff[PW-1:0] : hp);
   assign dec_pos = open_new ? SPP - SLOT_W'(1) : depth_ff[dec_pg] - SLOT_W'(1);
   assign rd_addr = AW'(AW'(dec_pg) * AW'(SLOTS_PER_PAGE)) + AW'(dec_pos);
   assign wr_addr = AW'(AW'(pg_ff) * AW'(SLOTS_PER_PAGE)) + AW'(pos_ff);
   assign wr_en   = (state_ff == ST_EXEC) && func_ff && act_ff;

   sba_stack_mem #(.DEPTH(DEPTH), .AW(AW)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sl_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Positions below the low-water mark were never written: they hold their index.
   assign slot_val = lwm_hit_ff ? pos_ff : rd_data;

   always_ff @(posedge clock) begin
      if (csr_we) begin
         bsz_ff <= csr_wdata;
      end
      if (reset) begin
         bsz_ff <= BSZ_W'(1);
      end
   end

   // Decode: latch request and decide what happens.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= in_func;
         pg_ff   <= dec_pg;
         if (in_func == FUNC_FREE) begin
            pos_ff     <= depth_ff[in_pg];
            sl_ff      <= in_sl;
            fail_ff    <= 1'b0;
            lwm_hit_ff <= 1'b0;
            act_ff     <= (LW'(in_pg) < opened_ff) && (in_sl < SPP) &&
                          (depth_ff[in_pg] < SPP);
         end else begin
            pos_ff     <= dec_pos;
            sl_ff      <= in_sl;
            fail_ff    <= (head_ff == NIL) && !open_new;
            act_ff     <= (head_ff != NIL) || open_new;
            lwm_hit_ff <= open_new || (dec_pos < lwm_ff[dec_pg]);
         end
      end
   end

   // Execute: update list and counts.
   logic [LW-1:0] n_l, q_l, h_l;
   logic          was_empty;
   assign n_l       = next_ff[pg_ff];
   assign q_l       = prev_ff[pg_ff];
   assign h_l       = head_ff;
   assign was_empty = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            depth_ff[i] <= '0;
            lwm_ff[i]   <= SPP;
            next_ff[i]  <= NIL;
            prev_ff[i]  <= NIL;
         end
         head_ff   <= NIL;
         opened_ff <= '0;
         total_ff  <= '0;
         listed_ff <= '0;
      end else if (state_ff == ST_EXEC && act_ff) begin
         if (func_ff == FUNC_ALLOC) begin
            if (LW'(pg_ff) == opened_ff && h_l == NIL) begin
               // Open a fresh page alone on the list.
               opened_ff <= opened_ff + LW'(1);
               lwm_ff[pg_ff] <= SPP;
               total_ff <= total_ff + TOTAL_W'(SLOTS_PER_PAGE) - TOTAL_W'(1);
               if (SLOTS_PER_PAGE == 1) begin
                  head_ff <= NIL;
               end else begin
                  head_ff   <= LW'(pg_ff);
                  next_ff[pg_ff] <= NIL;
                  prev_ff[pg_ff] <= NIL;
                  listed_ff <= listed_ff + LW'(1);
               end
            end else begin
               total_ff <= total_ff - TOTAL_W'(1);
               if (pos_ff == '0) begin
                  // Head page drains: unlink it.
                  head_ff <= n_l;
                  if (n_l != NIL) prev_ff[n_l[PW-1:0]] <= NIL;
                  next_ff[pg_ff] <= NIL;
                  listed_ff <= listed_ff - LW'(1);
               end
            end
            depth_ff[pg_ff] <= pos_ff;
         end else begin
            total_ff <= total_ff + TOTAL_W'(1);
            depth_ff[pg_ff] <= pos_ff + SLOT_W'(1);
            if (pos_ff < lwm_ff[pg_ff]) lwm_ff[pg_ff] <= pos_ff;
            if (was_empty || h_l != LW'(pg_ff)) begin
               // Unlink when listed, then push to the front.
               if (!was_empty) begin
                  if (q_l != NIL) next_ff[q_l[PW-1:0]] <= n_l;
                  if (n_l != NIL) prev_ff[n_l[PW-1:0]] <= q_l;
               end else begin
                  listed_ff <= listed_ff + LW'(1);
               end
               prev_ff[pg_ff] <= NIL;
               next_ff[pg_ff] <= h_l;
               if (h_l != NIL) prev_ff[h_l[PW-1:0]] <= LW'(pg_ff);
               head_ff <= LW'(pg_ff);
            end
         end
      end
   end

   // Result capture; counters are read after the execute update lands.
   logic [31:0] prod;
   assign prod = 32'(slot_val) * 32'(bsz_ff);
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         status_ff <= fail_ff ? STATUS_FULL : STATUS_OK;
         if (func_ff == FUNC_ALLOC && act_ff) begin
            rpage_ff <= pg_ff;
            rslot_ff <= slot_val;
            rofs_ff  <= prod[OFS_W-1:0];
         end else begin
            rpage_ff <= '0;
            rslot_ff <= '0;
            rofs_ff  <= '0;
         end
      end
   end

   // Counters hold still while the result waits, so drive the totals straight from them.
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {3'd0, 5'(listed_ff), total_ff, rofs_ff, rslot_ff, 4'(rpage_ff)};

   `CHK_IMP(a_list_bound, clock, reset, 1'b1, listed_ff <= opened_ff,
            "more pages listed than opened")
   `CHK_IMP(a_head_nil, clock, reset, state_ff == ST_IDLE, (head_ff == NIL) == (listed_ff == '0),
            "list head and listed count disagree")
   `CHK_NXT(a_exec_out, clock, reset, state_ff == ST_EXEC, state_ff == ST_OUT,
            "execute not followed by result")
   `CHK_IMP(a_fail_full, clock, reset, rsp_tvalid && rsp_tuser == STATUS_FULL,
            opened_ff == LW'(PAGES), "failure reported with unopened pages")
endmodule

### verif/tb_slab_block_allocator.sv
// Testbench for slab_block_allocator: drives allocate and free beats, predicts
// each response with a behavioral allocator and compares every field.
// Depends on sba_pkg and the slab_block_allocator RTL.
module tb_slab_block_allocator
   import sba_pkg::*;
();

   localparam int NPAGES = 16;
   localparam int NSLOTS = 255;
   localparam int NIL    = NPAGES;

   typedef struct packed {
      logic        status;
      logic [3:0]  page;
      logic [7:0]  slot;
      logic [23:0] offset;
      logic [11:0] free_blocks;
      logic [4:0]  pages_with_free;
   } alloc_rsp_type;

   // Behavioral allocator plus the queue of responses it has predicted.
   class slab_scoreboard;
      logic [7:0]  slot_mem [NPAGES*NSLOTS];
      int          depth [NPAGES];
      int          lwm [NPAGES];
      int          nxt [NPAGES];
      int          prv [NPAGES];
      int          head, opened, free_total, listed;
      logic [15:0] slot_bytes;
      alloc_rsp_type pending [$];
      int          errors, checked, n_alloc, n_free, n_full;

      function new();
         for (int i = 0; i < NPAGES; i++) begin
            depth[i] = 0; lwm[i] = NSLOTS; nxt[i] = NIL; prv[i] = NIL;
         end
         head = NIL; opened = 0; free_total = 0; listed = 0; slot_bytes = 1;
         errors = 0; checked = 0; n_alloc = 0; n_free = 0; n_full = 0;
      endfunction

      function void unlink(int p);
         if (prv[p] != NIL) nxt[prv[p]] = nxt[p];
         else head = nxt[p];
         if (nxt[p] != NIL) prv[nxt[p]] = prv[p];
         nxt[p] = NIL; prv[p] = NIL;
      endfunction

      function void to_front(int p);
         prv[p] = NIL; nxt[p] = head;
         if (head != NIL) prv[head] = p;
         head = p;
      endfunction

      // Note one accepted request beat and queue its expected response.
      function void note_request(logic func, logic [3:0] fpage, logic [7:0] fslot);
         alloc_rsp_type r;
         int p;
         r = '0;
         if (func == FUNC_ALLOC) begin
            n_alloc++;
            if (head == NIL && opened < NPAGES) begin
               p = opened++;
               depth[p] = NSLOTS; lwm[p] = NSLOTS;
               to_front(p);
               free_total += NSLOTS; listed++;
            end
            if (head == NIL) begin
               r.status = STATUS_FULL; n_full++;
            end else begin
               p = head;
               depth[p]--;
               r.slot = (depth[p] < lwm[p]) ? 8'(depth[p]) : slot_mem[p*NSLOTS + depth[p]];
               r.page = 4'(p);
               r.offset = 24'(24'(r.slot) * 24'(slot_bytes));
               free_total--;
               if (depth[p] == 0) begin
                  unlink(p); listed--;
               end
            end
         end else begin
            n_free++;
            p = int'(fpage);
            if (p < opened && fslot < NSLOTS && depth[p] < NSLOTS) begin
               if (depth[p] == 0) begin
                  to_front(p); listed++;
               end else if (head != p) begin
                  unlink(p); to_front(p);
               end
               slot_mem[p*NSLOTS + depth[p]] = fslot;
               if (depth[p] < lwm[p]) lwm[p] = depth[p];
               depth[p]++;
               free_total++;
            end
         end
         r.free_blocks = 12'(free_total);
         r.pages_with_free = 5'(listed);
         pending.push_back(r);
      endfunction

      // Compare one response beat against the oldest expectation.
      task check_response(logic status, logic [55:0] data);
         alloc_rsp_type e;
         alloc_rsp_type got;
         got = {status, data[3:0], data[11:4], data[35:12], data[47:36], data[52:48]};
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response beat", 0, got);
            return;
         end
         e = pending.pop_front();
         if (got.status != e.status) report_mismatch("status", e.status, got.status);
         if (got.page != e.page) report_mismatch("alloc_page", e.page, got.page);
         if (got.slot != e.slot) report_mismatch("alloc_slot", e.slot, got.slot);
         if (got.offset != e.offset) report_mismatch("byte_offset", e.offset, got.offset);
         if (got.free_blocks != e.free_blocks)
            report_mismatch("free_blocks", e.free_blocks, got.free_blocks);
         if (got.pages_with_free != e.pages_with_free)
            report_mismatch("pages_with_free", e.pages_with_free, got.pages_with_free);
         if (data[55:53] != 3'b000) report_mismatch("tdata fill", 0, data[55:53]);
      endtask

      task report_mismatch(string what, longint exp_v, longint got_v);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch on %s: expected %0h, got %0h (beat %0d)",
                     $realtime, what, exp_v, got_v, checked);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   slab_scoreboard sb = new();
   bit no_stall = 1'b0;

   slab_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Send one request beat, after a random gap when gaps are asked for and stalls are on; hold until taken.
   task send_req(logic func, logic [3:0] fpage, logic [7:0] fslot, bit gaps);
      int gap;
      gap = (gaps && !no_stall) ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, fslot, fpage};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, fpage, fslot);
      @(negedge clock);
   endtask

   task drop_valid();
      req_tvalid <= 1'b0;
   endtask

   // Hold off until every predicted response has arrived, then let the block settle.
   task drain();
      drop_valid();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_slot_bytes(logic [15:0] v);
      csr_we <= 1'b1; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.slot_bytes = v;
   endtask

   // Random response stall per beat, with stall-free stretches.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_stall ? 0 : $urandom_range(0, 14);
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tuser, rsp_tdata);
         @(negedge clock);
      end
   end

   // Stimulus: directed corners, then random phases across slot size settings.
   initial begin
      logic [15:0] sizes [5];
      int n;
      sizes = '{16'hFFFF, 16'd1, 16'd37, 16'h8000, 16'd0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: frees before any page opens, then first allocates.
      send_req(FUNC_FREE, 4'd0, 8'd0, 0);
      send_req(FUNC_FREE, 4'd15, 8'd255, 0);
      send_req(FUNC_ALLOC, 4'd15, 8'd255, 0);
      send_req(FUNC_ALLOC, 4'd0, 8'd0, 0);
      send_req(FUNC_FREE, 4'd0, 8'd254, 0);   // page 0 has room: pushed
      send_req(FUNC_FREE, 4'd0, 8'd255, 0);   // slot out of range: ignored
      send_req(FUNC_FREE, 4'd1, 8'd3, 0);     // unopened page: ignored
      send_req(FUNC_ALLOC, 4'd0, 8'd0, 0);
      send_req(FUNC_FREE, 4'd0, 8'd7, 0);
      send_req(FUNC_FREE, 4'd0, 8'd7, 0);     // repeated free pushed again
      send_req(FUNC_ALLOC, 4'd0, 8'd0, 0);
      drain();

      // Random phases: frees mostly target opened pages and valid slots.
      for (int ph = 0; ph < 5; ph++) begin
         write_slot_bytes(sizes[ph]);
         no_stall = (ph == 2);
         n = 0;
         while (n < 257) begin
            logic f;
            logic [3:0] pg;
            logic [7:0] sl;
            f = $urandom_range(0, 99) < 55 ? FUNC_FREE : FUNC_ALLOC;
            pg = $urandom_range(0, 9) == 0 ? 4'($urandom) :
                 4'($urandom_range(0, sb.opened > 0 ? sb.opened - 1 : 0));
            sl = $urandom_range(0, 19) == 0 ? 8'($urandom_range(250, 255)) : 8'($urandom);
            send_req(f, pg, sl, 1);
            n++;
         end
         drain();
      end
      repeat (20) @(negedge clock);
      $display("Covered %0d allocates (%0d pool-full), %0d frees, %0d responses checked.",
               sb.n_alloc, sb.n_full, sb.n_free, sb.checked);
      $display("Slot size swept through 1, 0, 37, 0x8000 and 0xFFFF bytes.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** slab_block_allocator: PASSED **");
      else
         $display("** slab_block_allocator: FAILED **");
      $finish;
   end

   // Watchdog: end the run after a generous fixed time.
   initial begin
      #20000000;
      $display("Timeout with %0d responses outstanding.", sb.pending.size());
      $display("** slab_block_allocator: FAILED **");
      $finish;
   end
endmodule
